// ===== sv/bcsn_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcsn_pkg
// Shared types and constants of the bounding-box center/scale normalizer.
// ----------------------------------------------------------------------------
package bcsn_pkg;

  // Pass selector carried with every vertex.
  localparam logic FUNC_MEASURE   = 1'b0;
  localparam logic FUNC_NORMALIZE = 1'b1;

  // Quotient format, signed Q1.15.
  localparam int QUOT_WIDTH = 16;
  localparam logic signed [QUOT_WIDTH-1:0] QUOT_MAX = 16'sh7fff;
  localparam logic signed [QUOT_WIDTH-1:0] QUOT_MIN = 16'sh8000;

  // Number of axes handled side by side.
  localparam int NUM_AXES = 3;

  typedef enum logic [1:0] {
    FS_IDLE,
    FS_LEN,
    FS_PUSH
  } front_state_t;

  typedef enum logic [1:0] {
    BS_IDLE,
    BS_DIV,
    BS_DONE
  } back_state_t;

  typedef struct packed {
    logic neg;
    logic ovf;
  } axis_flags_t;

  typedef struct packed {
    axis_flags_t [NUM_AXES-1:0] ax;
    logic                       degenerate;
  } job_flags_t;

endpackage

// ===== sv/bcsn_front.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcsn_front
// Accepts vertices, tracks the bounding box and prepares division jobs.
// ----------------------------------------------------------------------------
module bcsn_front import bcsn_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          func,
  input  logic                          first_vertex,
  input  logic signed [COORD_WIDTH-1:0] pos_x,
  input  logic signed [COORD_WIDTH-1:0] pos_y,
  input  logic signed [COORD_WIDTH-1:0] pos_z,
  input  logic                          q_full,
  output logic                          q_push,
  output job_flags_t                    job_flags,
  output logic [COORD_WIDTH-1:0]        job_len,
  output logic [COORD_WIDTH:0]          job_mag [NUM_AXES]
);

  localparam int W = COORD_WIDTH;

  front_state_t state, state_next;

  logic signed [W-1:0] hold [NUM_AXES];
  logic signed [W-1:0] min_b [NUM_AXES];
  logic signed [W-1:0] max_b [NUM_AXES];
  logic                bounds_valid;
  logic [W-1:0]        len, len_next;
  logic [W-1:0]        ext [NUM_AXES];
  logic signed [W-1:0] pos_in [NUM_AXES];
  logic [W+1:0]        diff [NUM_AXES];
  logic                accept;

  assign pos_in[0] = pos_x;
  assign pos_in[1] = pos_y;
  assign pos_in[2] = pos_z;
  assign accept    = push && !full;

  always_comb begin
    state_next = state;
    case (state)
      FS_IDLE: begin
        if (accept && func == FUNC_NORMALIZE) state_next = FS_LEN;
      end
      FS_LEN:  state_next = FS_PUSH;
      FS_PUSH: begin
        if (!q_full) state_next = FS_IDLE;
      end
      default: state_next = FS_IDLE;
    endcase
  end

  always_comb begin
    full   = (state != FS_IDLE);
    q_push = (state == FS_PUSH) && !q_full;
  end

  // Largest per-axis extent of the current box.
  always_comb begin
    for (int i = 0; i < NUM_AXES; i++) begin
      ext[i] = $unsigned(max_b[i] - min_b[i]);
    end
    len_next = ext[0];
    if (ext[1] > len_next) len_next = ext[1];
    if (ext[2] > len_next) len_next = ext[2];
  end

  // Numerator 2p - max - min, split into sign and magnitude.
  always_comb begin
    job_flags.degenerate = !bounds_valid || (len == '0);
    for (int i = 0; i < NUM_AXES; i++) begin
      diff[i] = {hold[i][W-1], hold[i], 1'b0}
              - {{2{max_b[i][W-1]}}, max_b[i]}
              - {{2{min_b[i][W-1]}}, min_b[i]};
      job_flags.ax[i].neg = diff[i][W+1];
      job_mag[i] = diff[i][W+1] ? (W+1)'(-diff[i]) : diff[i][W:0];
      job_flags.ax[i].ovf = {1'b0, job_mag[i]} >= {len, 2'b00};
    end
  end

  assign job_len = len;

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= FS_IDLE;
      bounds_valid <= 1'b0;
      for (int i = 0; i < NUM_AXES; i++) begin
        min_b[i] <= '0;
        max_b[i] <= '0;
      end
    end else begin
      state <= state_next;
      if (accept && func == FUNC_MEASURE) begin
        bounds_valid <= 1'b1;
        for (int i = 0; i < NUM_AXES; i++) begin
          if (first_vertex || !bounds_valid) begin
            min_b[i] <= pos_in[i];
            max_b[i] <= pos_in[i];
          end else begin
            if (pos_in[i] < min_b[i]) min_b[i] <= pos_in[i];
            if (pos_in[i] > max_b[i]) max_b[i] <= pos_in[i];
          end
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      for (int i = 0; i < NUM_AXES; i++) hold[i] <= pos_in[i];
    end
    if (state == FS_LEN) len <= len_next;
  end

endmodule

// ===== sv/bcsn_queue.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcsn_queue
// Short first-in first-out buffer between the front and the back.
// ----------------------------------------------------------------------------
module bcsn_queue #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             wr,
  input  logic [WIDTH-1:0] wr_data,
  output logic             q_full,
  input  logic             rd,
  output logic [WIDTH-1:0] rd_data,
  output logic             q_empty
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [AW-1:0]    wr_ptr, rd_ptr;
  logic [CW-1:0]    count;

  assign q_full  = (count == CW'(DEPTH));
  assign q_empty = (count == '0);
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (wr) wr_ptr <= (wr_ptr == AW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      if (rd) rd_ptr <= (rd_ptr == AW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      if (wr && !rd)      count <= count + 1'b1;
      else if (rd && !wr) count <= count - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem[wr_ptr] <= wr_data;
  end

endmodule

// ===== sv/bcsn_div.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcsn_div
// One radix-2 restoring divider lane with signed Q1.15 saturation.
// ----------------------------------------------------------------------------
module bcsn_div import bcsn_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                         clk,
  input  logic                         load,
  input  logic                         step,
  input  logic [COORD_WIDTH:0]         mag,
  input  logic [COORD_WIDTH-1:0]       len,
  input  logic                         neg,
  input  logic                         ovf,
  output logic signed [QUOT_WIDTH-1:0] quot
);

  localparam int W = COORD_WIDTH;

  // The partial remainder stays below four times the divisor.
  logic [W+1:0]          rem;
  logic [QUOT_WIDTH-1:0] q;
  logic [W:0]            twolen;
  logic                  ge;
  logic [W+1:0]          rem_sub;

  assign twolen  = {len, 1'b0};
  assign ge      = rem >= {1'b0, twolen};
  assign rem_sub = ge ? rem - {1'b0, twolen} : rem;

  always_ff @(posedge clk) begin
    if (load) begin
      rem <= {1'b0, mag};
      q   <= '0;
    end else if (step) begin
      rem <= {rem_sub[W:0], 1'b0};
      q   <= {q[QUOT_WIDTH-2:0], ge};
    end
  end

  always_comb begin
    if (!neg) begin
      quot = (ovf || q[QUOT_WIDTH-1]) ? QUOT_MAX : $signed(q);
    end else begin
      quot = (ovf || (q[QUOT_WIDTH-1] && (|q[QUOT_WIDTH-2:0]))) ? QUOT_MIN
             : $signed(-q);
    end
  end

endmodule

// ===== sv/bcsn_back.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// bcsn_back
// Runs the three divider lanes and holds the result for the consumer.
// ----------------------------------------------------------------------------
module bcsn_back import bcsn_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         q_empty,
  output logic                         q_pop,
  input  job_flags_t                   job_flags,
  input  logic [COORD_WIDTH-1:0]       job_len,
  input  logic [COORD_WIDTH:0]         job_mag [NUM_AXES],
  output logic                         empty,
  input  logic                         pop,
  output logic signed [QUOT_WIDTH-1:0] norm_x,
  output logic signed [QUOT_WIDTH-1:0] norm_y,
  output logic signed [QUOT_WIDTH-1:0] norm_z,
  output logic                         degenerate
);

  localparam int CNT_W = $clog2(QUOT_WIDTH);
  localparam logic [CNT_W-1:0] LAST_STEP = CNT_W'(QUOT_WIDTH - 1);

  back_state_t state, state_next;

  logic [CNT_W-1:0]             cnt;
  logic [COORD_WIDTH-1:0]       len_r;
  job_flags_t                   flags_r;
  logic                         out_valid;
  logic                         load, step, out_we;
  logic signed [QUOT_WIDTH-1:0] lane_q [NUM_AXES];

  for (genvar i = 0; i < NUM_AXES; i++) begin : g_lane
    bcsn_div #(.COORD_WIDTH(COORD_WIDTH)) u_div (
      .clk  (clk),
      .load (load),
      .step (step),
      .mag  (job_mag[i]),
      .len  (len_r),
      .neg  (flags_r.ax[i].neg),
      .ovf  (flags_r.ax[i].ovf),
      .quot (lane_q[i])
    );
  end

  always_comb begin
    state_next = state;
    case (state)
      BS_IDLE: begin
        if (!q_empty) state_next = BS_DIV;
      end
      BS_DIV: begin
        if (cnt == LAST_STEP) state_next = BS_DONE;
      end
      BS_DONE: begin
        if (!out_valid || pop) state_next = q_empty ? BS_IDLE : BS_DIV;
      end
      default: state_next = BS_IDLE;
    endcase
  end

  always_comb begin
    out_we = (state == BS_DONE) && (!out_valid || pop);
    load   = !q_empty && ((state == BS_IDLE) || out_we);
    q_pop  = load;
    step   = (state == BS_DIV);
  end

  assign empty = !out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= BS_IDLE;
      cnt       <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (load)      cnt <= '0;
      else if (step) cnt <= cnt + 1'b1;
      if (out_we)                out_valid <= 1'b1;
      else if (pop && out_valid) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      len_r   <= job_len;
      flags_r <= job_flags;
    end
    if (out_we) begin
      norm_x     <= flags_r.degenerate ? '0 : lane_q[0];
      norm_y     <= flags_r.degenerate ? '0 : lane_q[1];
      norm_z     <= flags_r.degenerate ? '0 : lane_q[2];
      degenerate <= flags_r.degenerate;
    end
  end

endmodule

// ===== sv/bbox_center_scale_normalize.sv =====
`timescale 1ns / 1ps
// Measure vertices transfer every cycle while the front is idle; normalize
// vertices pass the front's length and push states, then the back's 16-step
// radix-2 dividers plus a load. The divider lanes set the sustained rate of
// normalize results.
// Reset (rst, synchronous, active high) clears the bounds, the queue and the output.
// ----------------------------------------------------------------------------
// bbox_center_scale_normalize
// Centers vertices on their bounding box and scales them into a unit cube.
// ----------------------------------------------------------------------------
module bbox_center_scale_normalize import bcsn_pkg::*; #(
  parameter int COORD_WIDTH = 24
) (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          push,
  output logic                          full,
  input  logic                          func,
  input  logic                          first_vertex,
  input  logic signed [COORD_WIDTH-1:0] pos_x,
  input  logic signed [COORD_WIDTH-1:0] pos_y,
  input  logic signed [COORD_WIDTH-1:0] pos_z,
  output logic                          empty,
  input  logic                          pop,
  output logic signed [QUOT_WIDTH-1:0]  norm_x,
  output logic signed [QUOT_WIDTH-1:0]  norm_y,
  output logic signed [QUOT_WIDTH-1:0]  norm_z,
  output logic                          degenerate
);

  // A job carries the sign and overflow flags of each axis, the degenerate flag,
  // the largest extent and the three numerator magnitudes.
  localparam int MAG_W  = COORD_WIDTH + 1;
  localparam int FLAG_W = $bits(job_flags_t);
  localparam int JOB_W  = FLAG_W + COORD_WIDTH + NUM_AXES * MAG_W;
  localparam int QUEUE_DEPTH = 2;

  logic                   q_push, q_pop, q_full, q_empty;
  job_flags_t             f_flags, b_flags;
  logic [COORD_WIDTH-1:0] f_len, b_len;
  logic [MAG_W-1:0]       f_mag [NUM_AXES];
  logic [MAG_W-1:0]       b_mag [NUM_AXES];
  logic [JOB_W-1:0]       q_wr_data, q_rd_data;

  // The front takes every transfer. Measure vertices update the box in the
  // cycle of their transfer; normalize vertices register the largest extent in
  // the length state, then enter the queue with their numerators from the push state.
  bcsn_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .func         (func),
    .first_vertex (first_vertex),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .q_full       (q_full),
    .q_push       (q_push),
    .job_flags    (f_flags),
    .job_len      (f_len),
    .job_mag      (f_mag)
  );

  assign q_wr_data = {f_flags, f_len, f_mag[0], f_mag[1], f_mag[2]};

  // The queue lets the front keep measuring while the dividers are busy.
  bcsn_queue #(.WIDTH(JOB_W), .DEPTH(QUEUE_DEPTH)) u_queue (
    .clk     (clk),
    .rst     (rst),
    .wr      (q_push),
    .wr_data (q_wr_data),
    .q_full  (q_full),
    .rd      (q_pop),
    .rd_data (q_rd_data),
    .q_empty (q_empty)
  );

  assign {b_flags, b_len, b_mag[0], b_mag[1], b_mag[2]} = q_rd_data;

  // The back divides all three axes at once and keeps one finished result
  // in its output register, so the next division runs while it waits.
  bcsn_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
    .clk        (clk),
    .rst        (rst),
    .q_empty    (q_empty),
    .q_pop      (q_pop),
    .job_flags  (b_flags),
    .job_len    (b_len),
    .job_mag    (b_mag),
    .empty      (empty),
    .pop        (pop),
    .norm_x     (norm_x),
    .norm_y     (norm_y),
    .norm_z     (norm_z),
    .degenerate (degenerate)
  );

`ifndef SYNTHESIS
  // The front never writes a full queue.
  a_no_overflow : assert property (@(posedge clk) disable iff (rst)
    q_push |-> !q_full) else $error("queue written while full");

  // The back never reads an empty queue.
  a_no_underflow : assert property (@(posedge clk) disable iff (rst)
    q_pop |-> !q_empty) else $error("queue read while empty");

  // A measure vertex never blocks the next transfer.
  a_measure_fast : assert property (@(posedge clk) disable iff (rst)
    (push && !full && func == FUNC_MEASURE) |=> !full)
    else $error("front stalled after a measure vertex");

  // A degenerate result carries zero coordinates.
  a_degenerate_zero : assert property (@(posedge clk) disable iff (rst)
    (!empty && degenerate) |-> (norm_x == '0 && norm_y == '0 && norm_z == '0))
    else $error("degenerate result with nonzero coordinates");
`endif

endmodule

// ===== dv/tb.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the bounding-box center/scale normalizer.
// A directed table covers the corner cases first. Random point clouds follow:
// each is measured, then normalized, with some noise and out-of-box points
// mixed in. An in-bench model of the bounds predicts every result, and the
// results are checked field by field in arrival order.
// ----------------------------------------------------------------------------
module tb import bcsn_pkg::*; ();

  localparam int COORD_W      = 24;
  localparam int RANDOM_ITEMS = 400;
  localparam int HOLD_CYCLES  = 600;
  localparam int DRAIN_CYCLES = 40;
  localparam int CYCLE_LIMIT  = 500000;

  typedef logic signed [COORD_W-1:0]    coord_t;
  typedef logic signed [QUOT_WIDTH-1:0] quot_t;

  typedef struct packed {
    logic   func;
    logic   first;
    coord_t x;
    coord_t y;
    coord_t z;
  } vertex_t;

  typedef struct packed {
    quot_t x;
    quot_t y;
    quot_t z;
    logic  degenerate;
  } norm_t;

  typedef struct packed {
    vertex_t v;
    logic    typed;
    norm_t   want;
  } stim_row_t;

  localparam coord_t COORD_MAX  = {1'b0, {(COORD_W-1){1'b1}}};
  localparam coord_t COORD_MIN  = {1'b1, {(COORD_W-1){1'b0}}};
  localparam norm_t  NORM_DEGEN = '{x: '0, y: '0, z: '0, degenerate: 1'b1};
  localparam norm_t  NORM_NONE  = '0;

  // DUT ports.
  logic   clk;
  logic   rst;
  logic   push;
  logic   full;
  logic   func;
  logic   first_vertex;
  coord_t pos_x;
  coord_t pos_y;
  coord_t pos_z;
  logic   empty;
  logic   pop;
  quot_t  norm_x;
  quot_t  norm_y;
  quot_t  norm_z;
  logic   degenerate;

  bbox_center_scale_normalize #(.COORD_WIDTH(COORD_W)) u_dut (
    .clk          (clk),
    .rst          (rst),
    .push         (push),
    .full         (full),
    .func         (func),
    .first_vertex (first_vertex),
    .pos_x        (pos_x),
    .pos_y        (pos_y),
    .pos_z        (pos_z),
    .empty        (empty),
    .pop          (pop),
    .norm_x       (norm_x),
    .norm_y       (norm_y),
    .norm_z       (norm_z),
    .degenerate   (degenerate)
  );

  // 10 ns clock.
  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Bench copy of the bounding box. It is updated at the clock edge where a
  // vertex transfer happens, in the same order the block sees the vertices.
  coord_t box_lo_x, box_lo_y, box_lo_z;
  coord_t box_hi_x, box_hi_y, box_hi_z;
  bit     box_valid;

  // Results still owed by the block, oldest first.
  norm_t expected_norms[$];

  // Run bookkeeping.
  int  errors;
  int  cycles;
  int  n_measure;
  int  n_normalize;
  int  n_checked;
  int  n_degen_seen;
  int  n_sat_seen;
  int  n_full_cycles;
  bit  tx_steady;
  bit  rx_steady;
  bit  hold_req;
  bit  hold_seen_full;

  // One axis of the quotient: (2p - hi - lo) * 2^14 / span, truncated toward
  // zero and clamped to Q1.15. The center is never rounded on its own.
  function automatic quot_t axis_quot(longint p, longint lo, longint hi, longint span);
    longint q;
    q = ((2 * p - hi - lo) * 16384) / span;
    if (q > longint'(QUOT_MAX)) q = longint'(QUOT_MAX);
    if (q < longint'(QUOT_MIN)) q = longint'(QUOT_MIN);
    return quot_t'(q);
  endfunction

  // Advances the bounds for a measure vertex, or computes the result of a
  // normalize vertex. Returns 1 when the vertex produces a result.
  function automatic bit predict_vertex(input vertex_t v, output norm_t r);
    longint dx, dy, dz, span;
    r = NORM_NONE;
    if (v.func == FUNC_MEASURE) begin
      // A raised first flag, or no bounds yet, seeds the box from this vertex.
      if (v.first || !box_valid) begin
        box_lo_x = v.x; box_hi_x = v.x;
        box_lo_y = v.y; box_hi_y = v.y;
        box_lo_z = v.z; box_hi_z = v.z;
        box_valid = 1'b1;
      end else begin
        if (v.x < box_lo_x) box_lo_x = v.x;
        if (v.y < box_lo_y) box_lo_y = v.y;
        if (v.z < box_lo_z) box_lo_z = v.z;
        if (v.x > box_hi_x) box_hi_x = v.x;
        if (v.y > box_hi_y) box_hi_y = v.y;
        if (v.z > box_hi_z) box_hi_z = v.z;
      end
      return 1'b0;
    end
    // Normalize pass: the first flag plays no part here.
    dx = longint'(box_hi_x) - longint'(box_lo_x);
    dy = longint'(box_hi_y) - longint'(box_lo_y);
    dz = longint'(box_hi_z) - longint'(box_lo_z);
    span = dx;
    if (dy > span) span = dy;
    if (dz > span) span = dz;
    if (!box_valid || span <= 0) begin
      r = NORM_DEGEN;
    end else begin
      r.x = axis_quot(v.x, box_lo_x, box_hi_x, span);
      r.y = axis_quot(v.y, box_lo_y, box_hi_y, span);
      r.z = axis_quot(v.z, box_lo_z, box_hi_z, span);
      r.degenerate = 1'b0;
    end
    return 1'b1;
  endfunction

  // Idle length: mostly a few cycles, now and then a long stretch.
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 3);
    if (r < 95) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  // Coordinates at three scales so that both tiny boxes and full-width
  // values show up; the widest scale toggles every bit of the field.
  function automatic coord_t rand_coord(int scale);
    case (scale)
      0:       return coord_t'(int'($urandom_range(0, 512)) - 256);
      1:       return coord_t'(int'($urandom_range(0, 131072)) - 65536);
      default: return coord_t'($urandom);
    endcase
  endfunction

  // Drives one vertex from a falling edge, holds it until the transfer, and
  // then records what the block owes for it. A typed row supplies its own
  // expectation in place of the predicted one.
  task automatic send_vertex(input vertex_t v, input bit typed, input norm_t want);
    norm_t r;
    push         = 1'b1;
    func         = v.func;
    first_vertex = v.first;
    pos_x        = v.x;
    pos_y        = v.y;
    pos_z        = v.z;
    @(posedge clk);
    while (full) begin
      n_full_cycles++;
      if (hold_req) hold_seen_full = 1'b1;
      @(posedge clk);
    end
    if (predict_vertex(v, r)) begin
      expected_norms.insert(expected_norms.size(), typed ? want : r);
      n_normalize++;
    end else begin
      n_measure++;
    end
    @(negedge clk);
    push = 1'b0;
    if (!tx_steady && $urandom_range(0, 1) == 1) repeat (pick_gap()) @(negedge clk);
  endtask

  // The sender stops here until every owed result has been taken.
  task automatic wait_drained();
    while (expected_norms.size() != 0) @(negedge clk);
  endtask

  // Result checker. Outputs are sampled at the rising edge, where a result
  // transfer is pop high with empty low.
  always @(posedge clk) begin
    norm_t exp_r;
    if (!rst && pop && !empty) begin
      if (expected_norms.size() == 0) begin
        errors++;
        $error("result transfer with nothing owed: norm %0d %0d %0d degenerate %0b",
               norm_x, norm_y, norm_z, degenerate);
      end else begin
        exp_r = expected_norms.pop_front();
        n_checked++;
        if (degenerate) n_degen_seen++;
        if (norm_x == QUOT_MAX || norm_x == QUOT_MIN) n_sat_seen++;
        if (norm_y == QUOT_MAX || norm_y == QUOT_MIN) n_sat_seen++;
        if (norm_z == QUOT_MAX || norm_z == QUOT_MIN) n_sat_seen++;
        if (norm_x !== exp_r.x) begin
          errors++;
          $error("norm_x: expected %0d, actual %0d", exp_r.x, norm_x);
        end
        if (norm_y !== exp_r.y) begin
          errors++;
          $error("norm_y: expected %0d, actual %0d", exp_r.y, norm_y);
        end
        if (norm_z !== exp_r.z) begin
          errors++;
          $error("norm_z: expected %0d, actual %0d", exp_r.z, norm_z);
        end
        if (degenerate !== exp_r.degenerate) begin
          errors++;
          $error("degenerate: expected %0b, actual %0b", exp_r.degenerate, degenerate);
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $error("run did not finish within %0d cycles, %0d results still owed",
             CYCLE_LIMIT, expected_norms.size());
      $display("tb: errors");
      $finish;
    end
  end

  // Receiver. It stalls at random, runs without stalls while rx_steady is
  // set, and on request holds pop low for a long stretch of its own count so
  // that the block backs up and raises full.
  initial begin
    int stall_left;
    stall_left = 0;
    pop = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        pop = 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
        pop = 1'b1;
      end else if (stall_left > 0) begin
        pop = 1'b0;
        stall_left--;
      end else begin
        pop = 1'b1;
        if (!rx_steady && $urandom_range(0, 99) < 25) stall_left = pick_gap();
      end
    end
  end

  // Directed rows, then random clouds.
  stim_row_t directed_rows[$];

  task automatic add_row(input logic f, input logic fv, input coord_t x, input coord_t y,
                         input coord_t z, input bit typed = 1'b0,
                         input norm_t want = NORM_NONE);
    stim_row_t row_d;
    row_d.v     = '{func: f, first: fv, x: x, y: y, z: z};
    row_d.typed = typed;
    row_d.want  = want;
    directed_rows.insert(directed_rows.size(), row_d);
  endtask

  initial begin
    vertex_t cloud[$];
    vertex_t v;
    norm_t   full_scale_pos;
    norm_t   full_scale_neg;
    norm_t   clamped;
    int      n_random;
    int      cloud_idx;
    int      cloud_size;
    int      scale;
    bit      flat_cloud;

    errors = 0; cycles = 0; n_measure = 0; n_normalize = 0; n_checked = 0;
    n_degen_seen = 0; n_sat_seen = 0; n_full_cycles = 0;
    tx_steady = 1'b0; rx_steady = 1'b0; hold_req = 1'b0; hold_seen_full = 1'b0;
    box_lo_x = '0; box_lo_y = '0; box_lo_z = '0;
    box_hi_x = '0; box_hi_y = '0; box_hi_z = '0;
    box_valid = 1'b0;

    rst = 1'b1;
    push = 1'b0;
    func = FUNC_MEASURE;
    first_vertex = 1'b0;
    pos_x = '0;
    pos_y = '0;
    pos_z = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // With a box from the most negative to the most positive coordinate, the
    // box corners land at exactly plus and minus one half.
    full_scale_pos = '{x: 16'sd16384, y: 16'sd16384, z: 16'sd16384, degenerate: 1'b0};
    full_scale_neg = '{x: -16'sd16384, y: -16'sd16384, z: -16'sd16384, degenerate: 1'b0};
    // Box of x in [0, 256], y and z flat: far points clamp, y at the center is 0.
    clamped = '{x: QUOT_MAX, y: '0, z: QUOT_MIN, degenerate: 1'b0};

    // Normalize before any measurement: no bounds, flagged degenerate, and
    // the first flag changes nothing in the normalize pass.
    add_row(FUNC_NORMALIZE, 1'b0, 24'sd1, 24'sd2, 24'sd3, 1'b1, NORM_DEGEN);
    add_row(FUNC_NORMALIZE, 1'b1, -24'sd5, COORD_MAX, COORD_MIN, 1'b1, NORM_DEGEN);
    // A single measured point seeds the box without the first flag: zero extent.
    add_row(FUNC_MEASURE, 1'b0, 24'sd100, 24'sd200, 24'sd300);
    add_row(FUNC_NORMALIZE, 1'b0, 24'sd100, 24'sd200, 24'sd300, 1'b1, NORM_DEGEN);
    // Full-range box.
    add_row(FUNC_MEASURE, 1'b1, COORD_MIN, COORD_MIN, COORD_MIN);
    add_row(FUNC_MEASURE, 1'b0, COORD_MAX, COORD_MAX, COORD_MAX);
    add_row(FUNC_NORMALIZE, 1'b0, COORD_MAX, COORD_MAX, COORD_MAX, 1'b1, full_scale_pos);
    add_row(FUNC_NORMALIZE, 1'b0, COORD_MIN, COORD_MIN, COORD_MIN, 1'b1, full_scale_neg);
    add_row(FUNC_NORMALIZE, 1'b0, 24'sd0, 24'sd0, 24'sd0);
    add_row(FUNC_NORMALIZE, 1'b1, -24'sd1, 24'sd1, 24'sd12345);
    // Narrow box on x only, then a point far outside it and points near it.
    add_row(FUNC_MEASURE, 1'b1, 24'sd0, 24'sd0, 24'sd0);
    add_row(FUNC_MEASURE, 1'b0, 24'sd256, 24'sd0, 24'sd0);
    add_row(FUNC_NORMALIZE, 1'b0, COORD_MAX, 24'sd0, COORD_MIN, 1'b1, clamped);
    add_row(FUNC_NORMALIZE, 1'b0, 24'sd128, 24'sd0, 24'sd0);
    add_row(FUNC_NORMALIZE, 1'b0, 24'sd256, 24'sd1, -24'sd1);
    // Small box whose largest extent is on y, with an inside point measured.
    add_row(FUNC_MEASURE, 1'b1, 24'sd10, -24'sd20, 24'sd30);
    add_row(FUNC_MEASURE, 1'b0, -24'sd10, 24'sd20, 24'sd40);
    add_row(FUNC_MEASURE, 1'b0, 24'sd0, 24'sd0, 24'sd35);
    add_row(FUNC_NORMALIZE, 1'b0, 24'sd10, 24'sd20, 24'sd40);
    add_row(FUNC_NORMALIZE, 1'b0, -24'sd10, -24'sd20, 24'sd30);
    add_row(FUNC_NORMALIZE, 1'b0, 24'sd3, -24'sd7, 24'sd31);
    // The first flag throws the old box away: a lone point gives zero extent,
    // and a raised first flag in the normalize pass does not restart anything.
    add_row(FUNC_MEASURE, 1'b1, 24'sd7, 24'sd7, 24'sd7);
    add_row(FUNC_NORMALIZE, 1'b0, 24'sd7, 24'sd7, 24'sd7, 1'b1, NORM_DEGEN);
    add_row(FUNC_NORMALIZE, 1'b1, 24'sd7, 24'sd8, 24'sd7, 1'b1, NORM_DEGEN);

    foreach (directed_rows[i])
      send_vertex(directed_rows[i].v, directed_rows[i].typed, directed_rows[i].want);

    // Let the directed results come out before the random part starts.
    wait_drained();

    // Random part: mostly whole clouds (measure pass, then normalize pass),
    // with some stray vertices mixed in between.
    n_random = 0;
    cloud_idx = 0;
    while (n_random < RANDOM_ITEMS) begin
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 4) == 0);
      if ($urandom_range(0, 99) < 12) begin
        v.func  = logic'($urandom_range(0, 1));
        v.first = logic'($urandom_range(0, 1));
        v.x = rand_coord(2);
        v.y = rand_coord(2);
        v.z = rand_coord(2);
        send_vertex(v, 1'b0, NORM_NONE);
        n_random++;
      end else begin
        cloud_idx++;
        // One cloud is drained completely before it starts; another one is
        // large and is normalized while the receiver holds off, so that the
        // block fills up and pushes back on the sender.
        if (cloud_idx == 10) wait_drained();
        cloud_size = (cloud_idx == 3) ? 30 : $urandom_range(1, 12);
        scale = $urandom_range(0, 2);
        flat_cloud = ($urandom_range(0, 9) == 0);
        cloud.delete();
        for (int k = 0; k < cloud_size; k++) begin
          if (flat_cloud && k > 0) begin
            v = cloud[0];
          end else begin
            v.x = rand_coord(scale);
            v.y = rand_coord(scale);
            v.z = rand_coord(scale);
          end
          v.func = FUNC_MEASURE;
          // Usually the cloud restarts the box; sometimes it extends the
          // previous one.
          v.first = (k == 0) ? logic'($urandom_range(0, 4) != 0)
                             : logic'($urandom_range(0, 19) == 0 && k == cloud_size - 1);
          cloud.insert(cloud.size(), v);
          send_vertex(v, 1'b0, NORM_NONE);
          n_random++;
        end
        if (cloud_idx == 3) begin
          tx_steady = 1'b1;
          hold_req = 1'b1;
        end
        cloud.shuffle();
        foreach (cloud[k]) begin
          v = cloud[k];
          v.func  = FUNC_NORMALIZE;
          v.first = logic'($urandom_range(0, 1));
          // A few points get full-range coordinates, so they often land outside the box and saturate.
          if ($urandom_range(0, 9) == 0) begin
            v.x = rand_coord(2);
            v.y = rand_coord(2);
            v.z = rand_coord(2);
          end
          send_vertex(v, 1'b0, NORM_NONE);
          n_random++;
        end
      end
    end

    tx_steady = 1'b0;
    rx_steady = 1'b0;
    wait_drained();
    // Anything the block sends after the last owed result is flagged by the
    // checker during this window.
    repeat (DRAIN_CYCLES) @(negedge clk);

    $display("Sent %0d measure and %0d normalize vertices, %0d random clouds, %0d table rows.",
             n_measure, n_normalize, cloud_idx, directed_rows.size());
    $display("Checked %0d results: %0d degenerate, %0d clamped axes, %0d full cycles%s.",
             n_checked, n_degen_seen, n_sat_seen, n_full_cycles,
             hold_seen_full ? " (block filled during the long hold-off)" : "");
    if (errors == 0) begin
      $display("tb: clean");
    end else begin
      $display("tb: errors");
    end
    $finish;
  end

endmodule

// ===== files.f =====
sv/bcsn_pkg.sv
sv/bcsn_front.sv
sv/bcsn_queue.sv
sv/bcsn_div.sv
sv/bcsn_back.sv
sv/bbox_center_scale_normalize.sv
dv/tb.sv
